[hw/rtl/assert_macros.svh]
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/sc1a_pkg.sv]
package sc1a_pkg;

	// Set-1 codes with special handling
	localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2a;
	localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
	localparam logic [7:0] SC_LSHIFT_BREAK = 8'haa;
	localparam logic [7:0] SC_RSHIFT_BREAK = 8'hb6;
	localparam logic [7:0] SC_CTRL_MAKE    = 8'h1d;
	localparam logic [7:0] SC_CTRL_BREAK   = 8'h9d;
	localparam logic [7:0] SC_LEFT         = 8'h4b;
	localparam logic [7:0] SC_RIGHT        = 8'h4d;
	localparam logic [7:0] SC_UP           = 8'h48;
	localparam logic [7:0] SC_DOWN         = 8'h50;
	localparam int         RELEASE_BIT     = 7;

	// Output bytes
	localparam logic [7:0] CH_ESC     = 8'h1b;
	localparam logic [7:0] CH_BRACKET = 8'h5b;
	localparam logic [7:0] CH_UP      = 8'h41;
	localparam logic [7:0] CH_DOWN    = 8'h42;
	localparam logic [7:0] CH_RIGHT   = 8'h43;
	localparam logic [7:0] CH_LEFT    = 8'h44;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7a;
	localparam logic [7:0] CASE_DELTA = 8'h20;
	localparam logic [7:0] CTRL_DELTA = 8'h40;

	localparam int TABLE_LEN = 58;

	localparam logic [7:0] PLAIN_MAP [0:TABLE_LEN-1] = '{
		8'h00, 8'h1b, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
		8'h39, 8'h30, 8'h2d, 8'h3d, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
		8'h74, 8'h79, 8'h75, 8'h69, 8'h6f, 8'h70, 8'h5b, 8'h5d, 8'h0d, 8'h00,
		8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6a, 8'h6b, 8'h6c, 8'h3b,
		8'h27, 8'h60, 8'h00, 8'h5c, 8'h7a, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6e,
		8'h6d, 8'h2c, 8'h2e, 8'h2f, 8'h00, 8'h00, 8'h00, 8'h20
	};

	localparam logic [7:0] SHIFT_MAP [0:TABLE_LEN-1] = '{
		8'h00, 8'h1b, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5e, 8'h26, 8'h2a,
		8'h28, 8'h29, 8'h5f, 8'h2b, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
		8'h54, 8'h59, 8'h55, 8'h49, 8'h4f, 8'h50, 8'h7b, 8'h7d, 8'h0d, 8'h00,
		8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h3a,
		8'h22, 8'h7e, 8'h00, 8'h7c, 8'h5a, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4e,
		8'h4d, 8'h3c, 8'h3e, 8'h3f, 8'h00, 8'h00, 8'h00, 8'h20
	};

	typedef enum logic {
		KIND_CHAR,
		KIND_ARROW
	} kind_t;

	// Request from the lookup stage to the output sequencer
	typedef struct packed {
		kind_t      kind;
		logic       ctrl;
		logic [7:0] ch;
	} emit_req_t;

	typedef enum logic [1:0] {
		EM_EMPTY,
		EM_ESC,
		EM_BRACKET,
		EM_FINAL
	} emit_state_t;

	// Keymap lookup; codes past the table give zero
	function automatic logic [7:0] char_lookup(input logic shifted, input logic [6:0] idx);
		logic [7:0] ch;
		ch = 8'h00;
		if (idx < 7'(TABLE_LEN)) begin
			ch = shifted ? SHIFT_MAP[idx[5:0]] : PLAIN_MAP[idx[5:0]];
		end
		return ch;
	endfunction

endpackage

[hw/rtl/sc1a_emit.sv]
module sc1a_emit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	input  sc1a_pkg::emit_req_t   req,
	output logic                  take,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [7:0]            m_axis_tdata,  // [7:0] char_out
	output logic                  m_axis_tlast   // last
);
	import sc1a_pkg::*;

	emit_state_t state_q, state_d;
	logic [7:0]  data_q, data_d;
	logic [7:0]  letter_q;
	logic        out_fire;
	logic        load;

	// Control chord: fold lowercase up, then drop by 0x40 with wrap
	function automatic logic [7:0] ctrl_adjust(input logic ctrl, input logic [7:0] ch);
		logic [7:0] c;
		c = ch;
		if (ctrl) begin
			if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
				c = c - CASE_DELTA;
			end
			c = c - CTRL_DELTA;
		end
		return c;
	endfunction

	assign out_fire      = m_axis_tvalid && m_axis_tready;
	assign m_axis_tvalid = (state_q != EM_EMPTY);
	assign m_axis_tlast  = (state_q == EM_FINAL);
	assign m_axis_tdata  = data_q;

	// Next state and output byte
	always_comb begin
		logic free;
		free    = (state_q == EM_EMPTY) || (state_q == EM_FINAL && out_fire);
		take    = req_valid && free;
		load    = take;
		state_d = state_q;
		data_d  = data_q;
		unique case (state_q)
			EM_EMPTY, EM_FINAL: begin
				if (take) begin
					if (req.kind == KIND_ARROW) begin
						state_d = EM_ESC;
						data_d  = CH_ESC;
					end else begin
						state_d = EM_FINAL;
						data_d  = ctrl_adjust(req.ctrl, req.ch);
					end
				end else if (out_fire) begin
					state_d = EM_EMPTY;
				end
			end
			EM_ESC: begin
				if (out_fire) begin
					state_d = EM_BRACKET;
					data_d  = CH_BRACKET;
				end
			end
			EM_BRACKET: begin
				if (out_fire) begin
					state_d = EM_FINAL;
					data_d  = letter_q;
				end
			end
			default: begin
				state_d = EM_EMPTY;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= EM_EMPTY;
		end else begin
			state_q <= state_d;
		end
	end

	// Payload, no reset
	always_ff @(posedge clk) begin
		data_q <= data_d;
		if (load) begin
			letter_q <= req.ch;
		end
	end

endmodule

[hw/rtl/scancode_set1_to_ascii.sv]
// PS/2 set-1 scancode to ASCII translator.
//
// Input stream s_axis: one raw scancode byte per request in tdata. Output
// stream m_axis: translated bytes in tdata, tlast high on the final byte of
// the run a scancode causes. Shift and control make/break codes only update
// internal flags; other break codes produce nothing. Arrow make codes give a
// three-byte ESC '[' letter run, every other make code gives one byte from
// the keymap (shifted when shift is held, control-mapped when control is held).
//
// A byte passes the registered keymap ROM read and the sequencer's output
// register before it is presented. Throughput: one scancode per cycle for
// single-byte keys with tready high; an arrow holds the sequencer for its run.
// Codes that produce nothing are absorbed without using the output path.
//
// Reset clears both flags and empties the pipeline. When the receiver holds
// tready low, the presented byte stays put, one translated scancode waits in
// the lookup stage, and s_axis_tready drops only once that stage is occupied.
`include "assert_macros.svh"

module scancode_set1_to_ascii (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] scancode
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] char_out
	output logic       m_axis_tlast    // last
);
	import sc1a_pkg::*;

	logic      shift_held_q;
	logic      control_held_q;
	logic      valid_s1;
	emit_req_t req_s1;
	logic      take;
	logic      accept;

	// Decode results
	logic       set_shift, clr_shift, set_ctrl, clr_ctrl;
	logic       is_arrow;
	logic [7:0] arrow_ch;
	logic       produces;

	assign s_axis_tready = !valid_s1 || take;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// Scancode decoder
	always_comb begin
		set_shift = 1'b0;
		clr_shift = 1'b0;
		set_ctrl  = 1'b0;
		clr_ctrl  = 1'b0;
		is_arrow  = 1'b0;
		arrow_ch  = CH_UP;
		unique case (s_axis_tdata) inside
			SC_LSHIFT_MAKE, SC_RSHIFT_MAKE:   set_shift = 1'b1;
			SC_LSHIFT_BREAK, SC_RSHIFT_BREAK: clr_shift = 1'b1;
			SC_CTRL_MAKE:                     set_ctrl  = 1'b1;
			SC_CTRL_BREAK:                    clr_ctrl  = 1'b1;
			SC_UP: begin
				is_arrow = 1'b1;
				arrow_ch = CH_UP;
			end
			SC_DOWN: begin
				is_arrow = 1'b1;
				arrow_ch = CH_DOWN;
			end
			SC_RIGHT: begin
				is_arrow = 1'b1;
				arrow_ch = CH_RIGHT;
			end
			SC_LEFT: begin
				is_arrow = 1'b1;
				arrow_ch = CH_LEFT;
			end
			default: ;
		endcase
		produces = is_arrow ||
			(!s_axis_tdata[RELEASE_BIT] && !set_shift && !set_ctrl);
	end

	// Modifier flags, updated as each scancode is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_held_q   <= 1'b0;
			control_held_q <= 1'b0;
		end else if (accept) begin
			if (set_shift) begin
				shift_held_q <= 1'b1;
			end else if (clr_shift) begin
				shift_held_q <= 1'b0;
			end
			if (set_ctrl) begin
				control_held_q <= 1'b1;
			end else if (clr_ctrl) begin
				control_held_q <= 1'b0;
			end
		end
	end

	// Lookup stage occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept && produces) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	// Registered keymap ROM read
	always_ff @(posedge clk) begin
		if (accept && produces) begin
			req_s1.kind <= is_arrow ? KIND_ARROW : KIND_CHAR;
			req_s1.ctrl <= control_held_q;
			req_s1.ch   <= is_arrow ? arrow_ch
				: char_lookup(shift_held_q, s_axis_tdata[6:0]);
		end
	end

	sc1a_emit u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (valid_s1),
		.req           (req_s1),
		.take          (take),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	// An escape run never breaks off after its first or second byte
	`ASSERT_CLK(a_run_continues, (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid, "escape run broken")
	// Only ESC and bracket bytes go out without tlast
	`ASSERT_ALWAYS(a_mid_run_bytes, (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata == CH_ESC || m_axis_tdata == CH_BRACKET), "bad mid-run byte")
	// A waiting lookup result is held until the sequencer takes it
	`ASSERT_CLK(a_s1_held, (valid_s1 && !take) |=> (valid_s1 && $stable(req_s1)), "lookup stage lost")

endmodule
